FILE: sv/assert_macros.svh
// assertion helpers shared by the queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define SEQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define SEQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: sv/seq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package seq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int TIME_BITS   = 48;
	localparam int PRIO_BITS   = 8;
	localparam int ID_BITS     = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// operation codes
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_POP    = 2'd2;

	typedef struct packed {
		logic [1:0]                  func;
		logic [TIME_BITS-1:0]        event_time;
		logic signed [PRIO_BITS-1:0] event_priority;
		logic [ID_BITS-1:0]          event_id;
	} req_item_t;

	typedef struct packed {
		logic                        op_ok;
		logic [TIME_BITS-1:0]        out_time;
		logic signed [PRIO_BITS-1:0] out_priority;
		logic [ID_BITS-1:0]          out_id;
		logic                        queue_empty;
		logic [CNT_W-1:0]            entry_count;
	} rsp_item_t;

	// one stored event
	typedef struct packed {
		logic [TIME_BITS-1:0]        ev_time;
		logic signed [PRIO_BITS-1:0] ev_prio;
		logic [ID_BITS-1:0]          ev_id;
	} entry_t;

	// compare unit results
	typedef struct packed {
		logic goes_before;
		logic id_match;
	} cmp_res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_LAST,
		S_DEL,
		S_SHIFT,
		S_POP,
		S_FRONT,
		S_FRONT_CAP
	} state_t;

endpackage

`default_nettype wire

FILE: sv/seq_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module seq_cmp (
	input  seq_pkg::entry_t   cand,
	input  seq_pkg::entry_t   slot,
	output seq_pkg::cmp_res_t res
);
	import seq_pkg::*;

	logic time_lt;
	logic time_eq;
	logic prio_ge;

	// service order: earlier time, then higher priority, newest wins a full tie
	assign time_lt = cand.ev_time < slot.ev_time;
	assign time_eq = cand.ev_time == slot.ev_time;
	assign prio_ge = cand.ev_prio >= slot.ev_prio;

	assign res.goes_before = time_lt || (time_eq && prio_ge);
	assign res.id_match    = cand.ev_id == slot.ev_id;

endmodule

`default_nettype wire

FILE: sv/sorted_event_queue_unit.sv
`timescale 1ns / 1ps
// sequence to result valid: insert walks from the back, moving later entries up; pop reads the
// front, then shifts; delete searches from the back, then shifts on a match; the front is then read
// throughput: one item at a time, the next accepted once the result is registered, with the walk
// and shift through memory moving one slot per cycle
// a result held back by the receiver stalls the next item
// reset: occupancy is zero at once; the slot memory is not cleared and no sweep is run
`default_nettype none

`include "assert_macros.svh"

module sorted_event_queue_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  seq_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output seq_pkg::rsp_item_t  rsp
);
	import seq_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   occ_q, occ_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               ok_q, ok_d;
	logic               have_q, have_d;
	logic               rsp_valid_q, rsp_valid_d;
	req_item_t          req_q;
	entry_t             pop_q, pop_d;
	rsp_item_t          rsp_q, rsp_d;

	entry_t             mem [QUEUE_DEPTH];
	entry_t             rdata_q;
	logic [IDX_W-1:0]   raddr;
	logic [IDX_W-1:0]   waddr;
	entry_t             wdata;
	logic               mem_we;

	entry_t             new_ent;
	cmp_res_t           cmp;
	logic [CNT_W-1:0]   occ_m1;
	logic [IDX_W-1:0]   idx_inc;
	logic [IDX_W-1:0]   idx_dec;
	logic [CNT_W-1:0]   idx_nxt_c;
	logic               full;
	entry_t             rep_ent;

	assign new_ent = '{ev_time: req_q.event_time, ev_prio: req_q.event_priority,
		ev_id: req_q.event_id};
	assign occ_m1    = occ_q - 1'b1;
	assign idx_inc   = idx_q + 1'b1;
	assign idx_dec   = idx_q - 1'b1;
	assign idx_nxt_c = CNT_W'(idx_q) + 1'b1;
	assign full      = occ_q == CNT_W'(QUEUE_DEPTH);

	// shared compare unit: incoming event against the slot just read
	seq_cmp u_cmp (
		.cand (new_ent),
		.slot (rdata_q),
		.res  (cmp)
	);

	// slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// entry reported with the result
	always_comb begin
		if (have_q) begin
			rep_ent = pop_q;
		end else if (occ_q != '0) begin
			rep_ent = rdata_q;
		end else begin
			rep_ent = '0;
		end
	end

	// sequencer: next state, memory control and result
	always_comb begin
		state_d     = state_q;
		occ_d       = occ_q;
		idx_d       = idx_q;
		ok_d        = ok_q;
		have_d      = have_q;
		pop_d       = pop_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		raddr       = '0;
		mem_we      = 1'b0;
		waddr       = '0;
		wdata       = rdata_q;
		req_ready   = state_q == S_IDLE;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ok_d   = 1'b0;
					have_d = 1'b0;
					case (req.func)
						FUNC_INSERT: begin
							if (full) begin
								state_d = S_FRONT;
							end else if (occ_q == '0) begin
								state_d = S_INS_LAST;
							end else begin
								raddr   = occ_m1[IDX_W-1:0];
								idx_d   = occ_m1[IDX_W-1:0];
								state_d = S_INS;
							end
						end
						FUNC_DELETE: begin
							if (occ_q == '0) begin
								state_d = S_FRONT;
							end else begin
								raddr   = occ_m1[IDX_W-1:0];
								idx_d   = occ_m1[IDX_W-1:0];
								state_d = S_DEL;
							end
						end
						FUNC_POP: begin
							if (occ_q == '0) begin
								state_d = S_FRONT;
							end else begin
								raddr   = '0;
								idx_d   = '0;
								state_d = S_POP;
							end
						end
						default: begin
							state_d = S_FRONT;
						end
					endcase
				end
			end
			// walk down from the back, moving later entries up one slot
			S_INS: begin
				mem_we = 1'b1;
				waddr  = idx_inc;
				if (cmp.goes_before) begin
					wdata = rdata_q;
					if (idx_q == '0) begin
						state_d = S_INS_LAST;
					end else begin
						raddr = idx_dec;
						idx_d = idx_dec;
					end
				end else begin
					wdata   = new_ent;
					occ_d   = occ_q + 1'b1;
					ok_d    = 1'b1;
					state_d = S_FRONT;
				end
			end
			S_INS_LAST: begin
				mem_we  = 1'b1;
				waddr   = '0;
				wdata   = new_ent;
				occ_d   = occ_q + 1'b1;
				ok_d    = 1'b1;
				state_d = S_FRONT;
			end
			// search from the back for the id
			S_DEL: begin
				if (cmp.id_match) begin
					ok_d = 1'b1;
					if (idx_nxt_c < occ_q) begin
						raddr   = idx_inc;
						idx_d   = idx_inc;
						state_d = S_SHIFT;
					end else begin
						occ_d   = occ_m1;
						state_d = S_FRONT;
					end
				end else if (idx_q == '0) begin
					state_d = S_FRONT;
				end else begin
					raddr = idx_dec;
					idx_d = idx_dec;
				end
			end
			// close the gap, one entry down per cycle
			S_SHIFT: begin
				mem_we = 1'b1;
				waddr  = idx_dec;
				wdata  = rdata_q;
				if (idx_nxt_c < occ_q) begin
					raddr = idx_inc;
					idx_d = idx_inc;
				end else begin
					occ_d   = occ_m1;
					state_d = S_FRONT;
				end
			end
			S_POP: begin
				pop_d  = rdata_q;
				have_d = 1'b1;
				ok_d   = 1'b1;
				if (idx_nxt_c < occ_q) begin
					raddr   = idx_inc;
					idx_d   = idx_inc;
					state_d = S_SHIFT;
				end else begin
					occ_d   = occ_m1;
					state_d = S_FRONT;
				end
			end
			S_FRONT: begin
				raddr   = '0;
				state_d = S_FRONT_CAP;
			end
			// front slot stays on the read port until the output register frees up
			S_FRONT_CAP: begin
				raddr = '0;
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d.op_ok        = ok_q;
					rsp_d.out_time     = rep_ent.ev_time;
					rsp_d.out_priority = rep_ent.ev_prio;
					rsp_d.out_id       = rep_ent.ev_id;
					rsp_d.queue_empty  = occ_q == '0;
					rsp_d.entry_count  = occ_q;
					rsp_valid_d        = 1'b1;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			idx_q       <= '0;
			ok_q        <= 1'b0;
			have_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			occ_q       <= occ_d;
			idx_q       <= idx_d;
			ok_q        <= ok_d;
			have_q      <= have_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		pop_q <= pop_d;
		rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks; occupancy moves by at most one either way per cycle
	`SEQ_ASSERT(a_occ_bound, occ_q <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
	`SEQ_ASSERT(a_occ_step, $past(occ_q) - occ_q + 1'b1 <= 2'd2, "occupancy jumped")
	`SEQ_ASSERT_IMPL(a_shift_range, state_q == S_SHIFT, CNT_W'(waddr) < occ_q, "shift past end")
	`SEQ_ASSERT_IMPL(a_rsp_count, rsp_valid, rsp.queue_empty == (rsp.entry_count == '0), "empty flag")

endmodule

`default_nettype wire

FILE: bench/tb_sorted_event_queue_unit.sv
`timescale 1ns / 1ps

module tb_sorted_event_queue_unit;
	import seq_pkg::*;

	// unused operation code, handled by the block as a no-op
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};
	localparam int IDLE_PCT = 24;
	localparam int SETTLE_CYCLES = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_item_t rsp;

	// shadow copy of the event queue, slot 0 is the front
	entry_t shadow_slots[QUEUE_DEPTH];
	int shadow_count = 0;

	rsp_item_t pending_results[$];
	int mismatch_count = 0;
	int result_index = 0;
	bit no_idle = 1'b0;

	// tallies for the closing summary
	int n_insert = 0;
	int n_dropped = 0;
	int n_delete = 0;
	int n_delete_miss = 0;
	int n_pop = 0;
	int n_pop_empty = 0;
	int n_nop = 0;

	sorted_event_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// receiver stalls at random unless a no-idle stretch is running
	always @(posedge clk) begin
		rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic req_item_t make_req(input logic [1:0] func,
			input logic [TIME_BITS-1:0] t, input logic signed [PRIO_BITS-1:0] p,
			input logic [ID_BITS-1:0] id);
		req_item_t r;
		r.func = func;
		r.event_time = t;
		r.event_priority = p;
		r.event_id = id;
		return r;
	endfunction

	// next state of the queue and the result an operation produces
	function automatic rsp_item_t predict_queue_op(input req_item_t op);
		rsp_item_t r;
		entry_t front;
		bit popped;
		int k;
		int j;
		r = '0;
		front = '0;
		popped = 1'b0;
		case (op.func)
			FUNC_INSERT: begin
				if (shadow_count < QUEUE_DEPTH) begin
					// first slot the new event goes ahead of; ties go to the newest
					k = 0;
					while (k < shadow_count &&
							!(op.event_time < shadow_slots[k].ev_time ||
							(op.event_time == shadow_slots[k].ev_time &&
							$signed(op.event_priority) >= $signed(shadow_slots[k].ev_prio))))
						k++;
					for (j = shadow_count; j > k; j--)
						shadow_slots[j] = shadow_slots[j - 1];
					shadow_slots[k].ev_time = op.event_time;
					shadow_slots[k].ev_prio = op.event_priority;
					shadow_slots[k].ev_id = op.event_id;
					shadow_count++;
					r.op_ok = 1'b1;
				end
			end
			FUNC_DELETE: begin
				// match farthest from the front wins
				for (k = shadow_count - 1; k >= 0; k--) begin
					if (shadow_slots[k].ev_id == op.event_id) begin
						for (j = k; j < shadow_count - 1; j++)
							shadow_slots[j] = shadow_slots[j + 1];
						shadow_count--;
						r.op_ok = 1'b1;
						break;
					end
				end
			end
			FUNC_POP: begin
				if (shadow_count > 0) begin
					front = shadow_slots[0];
					popped = 1'b1;
					for (j = 0; j < shadow_count - 1; j++)
						shadow_slots[j] = shadow_slots[j + 1];
					shadow_count--;
					r.op_ok = 1'b1;
				end
			end
			default: ;
		endcase
		if (!popped && shadow_count > 0)
			front = shadow_slots[0];
		r.out_time = front.ev_time;
		r.out_priority = front.ev_prio;
		r.out_id = front.ev_id;
		r.queue_empty = (shadow_count == 0);
		r.entry_count = shadow_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $time, result_index,
			what, got, want);
		mismatch_count++;
	endtask

	// compare every accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing outstanding", 64'(rsp), 64'(0));
			end else begin
				want = pending_results.pop_front();
				if (rsp.op_ok !== want.op_ok)
					report_mismatch("op_ok", 64'(rsp.op_ok), 64'(want.op_ok));
				if (rsp.out_time !== want.out_time)
					report_mismatch("out_time", 64'(rsp.out_time), 64'(want.out_time));
				if (rsp.out_priority !== want.out_priority)
					report_mismatch("out_priority", 64'(rsp.out_priority),
						64'(want.out_priority));
				if (rsp.out_id !== want.out_id)
					report_mismatch("out_id", 64'(rsp.out_id), 64'(want.out_id));
				if (rsp.queue_empty !== want.queue_empty)
					report_mismatch("queue_empty", 64'(rsp.queue_empty),
						64'(want.queue_empty));
				if (rsp.entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(rsp.entry_count),
						64'(want.entry_count));
			end
			result_index++;
		end
	end

	// hand one item to the block, predicting its result on acceptance
	task automatic send_item(input req_item_t item);
		rsp_item_t want;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		want = predict_queue_op(item);
		pending_results = {pending_results, want};
		case (item.func)
			FUNC_INSERT: begin
				n_insert++;
				if (!want.op_ok)
					n_dropped++;
			end
			FUNC_DELETE: begin
				n_delete++;
				if (!want.op_ok)
					n_delete_miss++;
			end
			FUNC_POP: begin
				n_pop++;
				if (!want.op_ok)
					n_pop_empty++;
			end
			default: n_nop++;
		endcase
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// times cluster on a few values so that ties happen often
	function automatic logic [TIME_BITS-1:0] rand_time();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return TIME_BITS'($urandom_range(7));
		if (roll < 50)
			return '0;
		if (roll < 60)
			return TIME_MAX;
		return TIME_BITS'({$urandom, $urandom});
	endfunction

	function automatic logic signed [PRIO_BITS-1:0] rand_prio();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return PRIO_BITS'($urandom_range(4) - 2);
		if (roll < 50)
			return PRIO_BITS'(-128);
		if (roll < 60)
			return PRIO_BITS'(127);
		return PRIO_BITS'($urandom);
	endfunction

	// small id pool gives duplicate ids
	function automatic logic [ID_BITS-1:0] rand_id();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return $urandom_range(15);
		if (roll < 60)
			return '0;
		if (roll < 70)
			return ID_MAX;
		return $urandom;
	endfunction

	// delete mostly targets an id that is stored
	function automatic logic [ID_BITS-1:0] delete_target();
		if (shadow_count > 0 && $urandom_range(99) < 70)
			return shadow_slots[$urandom_range(shadow_count - 1)].ev_id;
		return rand_id();
	endfunction

	function automatic req_item_t rand_insert();
		return make_req(FUNC_INSERT, rand_time(), rand_prio(), rand_id());
	endfunction

	// filler fields on delete, pop and no-op are random too
	function automatic req_item_t rand_other(input logic [1:0] func);
		if (func == FUNC_DELETE)
			return make_req(func, rand_time(), rand_prio(), delete_target());
		return make_req(func, rand_time(), rand_prio(), rand_id());
	endfunction

	// operations on an empty queue
	task automatic test_empty_queue();
		send_item(make_req(FUNC_POP, '0, '0, '0));
		send_item(make_req(FUNC_DELETE, '0, '0, 32'd7));
		send_item(make_req(FUNC_NOP, TIME_MAX, -8'sd1, ID_MAX));
	endtask

	// widest and narrowest field values
	task automatic test_field_extremes();
		int i;
		send_item(make_req(FUNC_INSERT, TIME_MAX, -8'sd128, ID_MAX));
		send_item(make_req(FUNC_INSERT, '0, 8'sd127, '0));
		send_item(make_req(FUNC_INSERT, '0, -8'sd128, 32'h5a5a_5a5a));
		send_item(make_req(FUNC_INSERT, TIME_MAX, 8'sd127, 32'd1));
		for (i = 0; i < 4; i++)
			send_item(make_req(FUNC_POP, '0, '0, '0));
	endtask

	// equal time: higher priority first, newest first on full ties
	task automatic test_tie_order();
		int i;
		send_item(make_req(FUNC_INSERT, 48'd100, 8'sd5, 32'd10));
		send_item(make_req(FUNC_INSERT, 48'd100, 8'sd5, 32'd11));
		send_item(make_req(FUNC_INSERT, 48'd100, -8'sd3, 32'd12));
		send_item(make_req(FUNC_INSERT, 48'd100, 8'sd100, 32'd13));
		send_item(make_req(FUNC_NOP, '0, '0, '0));
		for (i = 0; i < 4; i++)
			send_item(make_req(FUNC_POP, '0, '0, '0));
	endtask

	// duplicate ids, unknown id, delete down to empty
	task automatic test_delete_cases();
		send_item(make_req(FUNC_INSERT, 48'd50, 8'sd0, 32'd20));
		send_item(make_req(FUNC_INSERT, 48'd60, 8'sd0, 32'd20));
		send_item(make_req(FUNC_DELETE, '0, '0, 32'd20));
		send_item(make_req(FUNC_DELETE, '0, '0, 32'd99));
		send_item(make_req(FUNC_DELETE, '0, '0, 32'd20));
	endtask

	// fill to capacity, push past it, then drain by pop and delete
	task automatic test_fill_overflow(input int rounds);
		int r;
		int i;
		for (r = 0; r < rounds; r++) begin
			while (shadow_count < QUEUE_DEPTH)
				send_item(rand_insert());
			for (i = 0; i < 2 + $urandom_range(2); i++)
				send_item(rand_insert());
			while (shadow_count > 0)
				send_item(rand_other($urandom_range(1) ? FUNC_POP : FUNC_DELETE));
			send_item(rand_other(FUNC_POP));
		end
	endtask

	// random mix, in stretches that grow or shrink the queue, chosen at random
	task automatic test_mixed_traffic(input int n_items);
		int i;
		int roll;
		int ins_pct;
		bit growing;
		growing = 1'b1;
		for (i = 0; i < n_items; i++) begin
			if (i % 40 == 0)
				growing = ($urandom_range(1) != 0);
			ins_pct = growing ? 70 : 25;
			roll = $urandom_range(99);
			if (roll < ins_pct)
				send_item(rand_insert());
			else if (roll < ins_pct + (99 - ins_pct) / 2)
				send_item(rand_other(FUNC_DELETE));
			else if (roll < 98)
				send_item(rand_other(FUNC_POP));
			else
				send_item(rand_other(FUNC_NOP));
		end
	endtask

	// sender holds off until every result is back, then resumes
	task automatic test_hold_until_drained();
		test_mixed_traffic(20);
		wait_drain();
		test_mixed_traffic(20);
	endtask

	// main sequence
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_field_extremes();
		test_tie_order();
		test_delete_cases();
		test_fill_overflow(3);
		test_mixed_traffic(480);
		test_hold_until_drained();
		no_idle = 1'b1;
		test_mixed_traffic(300);
		no_idle = 1'b0;
		test_mixed_traffic(240);

		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", 64'(pending_results.size()), 64'(0));

		$display("ran %0d inserts (%0d refused when full), %0d deletes (%0d unknown ids),",
			n_insert, n_dropped, n_delete, n_delete_miss);
		$display("%0d pops (%0d on empty), %0d no-op codes; %0d results checked",
			n_pop, n_pop_empty, n_nop, result_index);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/seq_pkg.sv
sv/seq_cmp.sv
sv/sorted_event_queue_unit.sv
bench/tb_sorted_event_queue_unit.sv
